>>> rtl/bcz_pkg.sv
// Shared types, constants and helpers for the bilinear center zoom block.
// Used by bcz_coord, bcz_blend and the top level; depends on nothing else.
`default_nettype none

package bcz_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 10;

  localparam int COORD_W  = 9;
  localparam int PIX_W    = 8;
  localparam int DIM_W    = 10;
  localparam int ZOOM_W   = 15;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  localparam int DX_W   = ((COORD_W > X_W) ? COORD_W : X_W) + 2;
  localparam int DY_W   = ((COORD_W > Y_W) ? COORD_W : Y_W) + 2;
  localparam int PRODX_W = DX_W + ZOOM_W + 1;
  localparam int PRODY_W = DY_W + ZOOM_W + 1;

  localparam int WGT_W = 2 * FRAC_BITS + 1;
  localparam int ACC_W = 2 * FRAC_BITS + PIX_W;

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ZOOM_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ZOOM_Y   = CFG_IDX_W'(3);

  localparam logic [1:0] PHASE_TL = 2'd0;
  localparam logic [1:0] PHASE_TR = 2'd1;
  localparam logic [1:0] PHASE_BL = 2'd2;
  localparam logic [1:0] PHASE_BR = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [PIX_W-1:0]   pixel_out;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [ZOOM_W-1:0] inv_zoom_x;
    logic [ZOOM_W-1:0] inv_zoom_y;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic                 in_bounds;
    logic [X_W-1:0]       x0;
    logic [X_W-1:0]       x1;
    logic [Y_W-1:0]       y0;
    logic [Y_W-1:0]       y1;
    logic [FRAC_BITS-1:0] p;
    logic [FRAC_BITS-1:0] q;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [PIX_W-1:0]     pixel_in;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               zero;
    logic [WGT_W-1:0]   weight;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } beat_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ADDR_W-1:0] x,
                                                 input logic [ADDR_W-1:0] y);
    return ADDR_W'(y * ADDR_W'(MAX_WIDTH) + x);
  endfunction

endpackage

`default_nettype wire

>>> rtl/bcz_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Holds the frame store; depends on nothing else.
`default_nettype none

module bcz_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 18,
  parameter int DEPTH  = 262144
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/bcz_coord.sv
// Input register, centered coordinate multiply and floor/fraction split.
// Depends on bcz_pkg; feeds the read sequencer in the top level.
`default_nettype none

module bcz_coord (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bcz_pkg::cfg_t cfg,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bcz_pkg::req_t req,
  output logic               job_valid,
  input  wire logic          job_ready,
  output bcz_pkg::job_t      job
);

  localparam int FX_W = bcz_pkg::PRODX_W - bcz_pkg::FRAC_BITS;
  localparam int FY_W = bcz_pkg::PRODY_W - bcz_pkg::FRAC_BITS;

  logic                 a_valid;
  bcz_pkg::req_t        a_req;
  logic                 b_valid;
  bcz_pkg::req_t        b_req;
  logic signed [bcz_pkg::PRODX_W-1:0] b_prod_x;
  logic signed [bcz_pkg::PRODY_W-1:0] b_prod_y;

  logic a_ready;
  logic b_ready;

  logic [bcz_pkg::X_W:0]   w_eff;
  logic [bcz_pkg::Y_W:0]   h_eff;
  logic [bcz_pkg::X_W-1:0] hx;
  logic [bcz_pkg::Y_W-1:0] hy;

  logic signed [bcz_pkg::DX_W-1:0]   dx;
  logic signed [bcz_pkg::DY_W-1:0]   dy;
  logic signed [bcz_pkg::ZOOM_W:0]   zx;
  logic signed [bcz_pkg::ZOOM_W:0]   zy;
  logic signed [bcz_pkg::PRODX_W-1:0] prod_x_next;
  logic signed [bcz_pkg::PRODY_W-1:0] prod_y_next;

  logic signed [FX_W-1:0] fx;
  logic signed [FY_W-1:0] fy;
  logic signed [FX_W-1:0] hxs;
  logic signed [FY_W-1:0] hys;
  logic signed [FX_W-1:0] x0_sum;
  logic signed [FY_W-1:0] y0_sum;
  logic [bcz_pkg::X_W:0]   xl_w;
  logic [bcz_pkg::Y_W:0]   yl_w;
  logic [bcz_pkg::X_W-1:0] x0;
  logic [bcz_pkg::Y_W-1:0] y0;

  assign a_ready   = !a_valid || b_ready;
  assign b_ready   = !b_valid || job_ready;
  assign req_ready = a_ready;

  always_comb begin
    w_eff = (int'(cfg.image_width) > bcz_pkg::MAX_WIDTH) ?
            (bcz_pkg::X_W + 1)'(bcz_pkg::MAX_WIDTH) : (bcz_pkg::X_W + 1)'(cfg.image_width);
    h_eff = (int'(cfg.image_height) > bcz_pkg::MAX_HEIGHT) ?
            (bcz_pkg::Y_W + 1)'(bcz_pkg::MAX_HEIGHT) : (bcz_pkg::Y_W + 1)'(cfg.image_height);
    hx = w_eff[bcz_pkg::X_W:1];
    hy = h_eff[bcz_pkg::Y_W:1];
  end

  always_comb begin
    dx = signed'(bcz_pkg::DX_W'(a_req.col)) - signed'(bcz_pkg::DX_W'(hx));
    dy = signed'(bcz_pkg::DY_W'(a_req.row)) - signed'(bcz_pkg::DY_W'(hy));
    zx = signed'({1'b0, cfg.inv_zoom_x});
    zy = signed'({1'b0, cfg.inv_zoom_y});
    prod_x_next = dx * zx;
    prod_y_next = dy * zy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= req_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req_valid) begin
      a_req <= req;
    end
    if (b_ready && a_valid) begin
      b_req    <= a_req;
      b_prod_x <= prod_x_next;
      b_prod_y <= prod_y_next;
    end
  end

  always_comb begin
    fx     = b_prod_x[bcz_pkg::PRODX_W-1:bcz_pkg::FRAC_BITS];
    fy     = b_prod_y[bcz_pkg::PRODY_W-1:bcz_pkg::FRAC_BITS];
    hxs    = signed'(FX_W'(hx));
    hys    = signed'(FY_W'(hy));
    x0_sum = fx + hxs;
    y0_sum = fy + hys;
    x0     = x0_sum[bcz_pkg::X_W-1:0];
    y0     = y0_sum[bcz_pkg::Y_W-1:0];
    xl_w   = {hx, 1'b0} - 1'b1;
    yl_w   = {hy, 1'b0} - 1'b1;

    job.cmd       = b_req.cmd;
    job.in_bounds = (fx >= -hxs) && (fx < hxs) && (fy >= -hys) && (fy < hys);
    job.x0        = x0;
    job.y0        = y0;
    job.x1        = (x0 == xl_w[bcz_pkg::X_W-1:0]) ? x0 : bcz_pkg::X_W'(x0 + 1'b1);
    job.y1        = (y0 == yl_w[bcz_pkg::Y_W-1:0]) ? y0 : bcz_pkg::Y_W'(y0 + 1'b1);
    job.p         = b_prod_x[bcz_pkg::FRAC_BITS-1:0];
    job.q         = b_prod_y[bcz_pkg::FRAC_BITS-1:0];
    job.col       = b_req.col;
    job.row       = b_req.row;
    job.pixel_in  = b_req.pixel_in;
    job_valid     = b_valid;
  end

endmodule

`default_nettype wire

>>> rtl/bcz_blend.sv
// Weighted accumulation of the four neighbor reads and the result queue.
// Depends on bcz_pkg; takes read beats from the top-level sequencer.
`default_nettype none

module bcz_blend (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bcz_pkg::beat_t              beat,
  input  wire logic [bcz_pkg::PIX_W-1:0]   rdata,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output bcz_pkg::rsp_t                    rsp
);

  bcz_pkg::beat_t                    beat_q;
  logic [bcz_pkg::ACC_W-1:0]         acc;
  logic [bcz_pkg::ACC_W-1:0]         acc_next;
  logic [bcz_pkg::WGT_W+bcz_pkg::PIX_W-1:0] term;
  bcz_pkg::rsp_t                     fifo [bcz_pkg::OUT_DEPTH];
  bcz_pkg::rsp_t                     result;
  logic [bcz_pkg::PTR_W-1:0]         head;
  logic [bcz_pkg::PTR_W-1:0]         tail;
  logic [bcz_pkg::CNT_W-1:0]         count;
  logic                              push;
  logic                              pop;

  always_comb begin
    term     = beat_q.weight * rdata;
    acc_next = (beat_q.first ? '0 : acc) + bcz_pkg::ACC_W'(term);
    result.out_col   = beat_q.col;
    result.out_row   = beat_q.row;
    result.pixel_out = beat_q.zero ? '0 :
                       acc_next[bcz_pkg::ACC_W-1 -: bcz_pkg::PIX_W];
    push      = beat_q.valid && beat_q.last;
    rsp_valid = (count != '0);
    pop       = rsp_valid && rsp_ready;
    rsp       = fifo[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_q <= '0;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
    end else begin
      beat_q <= beat;
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + bcz_pkg::CNT_W'(push) - bcz_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (beat_q.valid && !beat_q.zero) begin
      acc <= acc_next;
    end
    if (push) begin
      fifo[tail] <= result;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != bcz_pkg::CNT_W'(bcz_pkg::OUT_DEPTH)) || pop)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bcz_pkg::CNT_W'(bcz_pkg::OUT_DEPTH))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

>>> rtl/bilinear_center_zoom.sv
// Bilinear zoom about the image center over an 8-bit grey frame store held in one
// single-port RAM. A store transaction takes one write through the frame store port. A compute
// transaction whose source position lies inside the image reads its four neighbors in turn
// through that single port; one that falls outside reads none. Each result queues in a
// four-entry output buffer, so input keeps flowing while results wait, until it is full.
// The frame store needs no clearing after reset.
// Depends on bcz_pkg, bcz_coord, bcz_ram and bcz_blend.
`default_nettype none

module bilinear_center_zoom (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire bcz_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output bcz_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bcz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcz_pkg::CFG_W-1:0]       cfg_data
);

  bcz_pkg::cfg_t cfg;

  logic          job_valid;
  logic          job_ready;
  bcz_pkg::job_t job;

  logic          c_valid;
  bcz_pkg::job_t c_job;
  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic          c_done;

  logic [bcz_pkg::CNT_W-1:0] pending;
  logic                      credit;

  bcz_pkg::beat_t beat;

  logic                         ram_en;
  logic                         ram_we;
  logic [bcz_pkg::ADDR_W-1:0]   ram_addr;
  logic [bcz_pkg::PIX_W-1:0]    ram_rdata;

  logic [bcz_pkg::FRAC_BITS:0]   one_s;
  logic [bcz_pkg::FRAC_BITS:0]   sp;
  logic [bcz_pkg::FRAC_BITS:0]   sq;
  logic [bcz_pkg::FRAC_BITS:0]   wa;
  logic [bcz_pkg::FRAC_BITS:0]   wb;
  logic [2*bcz_pkg::FRAC_BITS+1:0] wprod;
  logic [bcz_pkg::ADDR_W-1:0]    ax;
  logic [bcz_pkg::ADDR_W-1:0]    ay;
  logic                          store_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= bcz_pkg::DIM_W'(256);
      cfg.image_height <= bcz_pkg::DIM_W'(256);
      cfg.inv_zoom_x   <= bcz_pkg::ZOOM_W'(512);
      cfg.inv_zoom_y   <= bcz_pkg::ZOOM_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcz_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[bcz_pkg::DIM_W-1:0];
        bcz_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[bcz_pkg::DIM_W-1:0];
        bcz_pkg::REG_INV_ZOOM_X:   cfg.inv_zoom_x   <= cfg_data[bcz_pkg::ZOOM_W-1:0];
        bcz_pkg::REG_INV_ZOOM_Y:   cfg.inv_zoom_y   <= cfg_data[bcz_pkg::ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  bcz_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  assign job_ready = !c_valid || c_done;
  assign credit    = (pending < bcz_pkg::CNT_W'(bcz_pkg::OUT_DEPTH));

  always_comb begin
    one_s = {1'b1, {bcz_pkg::FRAC_BITS{1'b0}}};
    sp    = one_s - {1'b0, c_job.p};
    sq    = one_s - {1'b0, c_job.q};
    case (phase)
      bcz_pkg::PHASE_TL: begin
        wa = sq;
        wb = sp;
        ax = bcz_pkg::ADDR_W'(c_job.x0);
        ay = bcz_pkg::ADDR_W'(c_job.y0);
      end
      bcz_pkg::PHASE_TR: begin
        wa = sq;
        wb = {1'b0, c_job.p};
        ax = bcz_pkg::ADDR_W'(c_job.x1);
        ay = bcz_pkg::ADDR_W'(c_job.y0);
      end
      bcz_pkg::PHASE_BL: begin
        wa = {1'b0, c_job.q};
        wb = sp;
        ax = bcz_pkg::ADDR_W'(c_job.x0);
        ay = bcz_pkg::ADDR_W'(c_job.y1);
      end
      default: begin
        wa = {1'b0, c_job.q};
        wb = {1'b0, c_job.p};
        ax = bcz_pkg::ADDR_W'(c_job.x1);
        ay = bcz_pkg::ADDR_W'(c_job.y1);
      end
    endcase
    wprod    = wa * wb;
    store_ok = (int'(c_job.col) < bcz_pkg::MAX_WIDTH) &&
               (int'(c_job.row) < bcz_pkg::MAX_HEIGHT);

    c_done      = 1'b0;
    phase_next  = phase;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = bcz_pkg::mem_addr(ax, ay);
    beat.valid  = 1'b0;
    beat.first  = (phase == bcz_pkg::PHASE_TL);
    beat.last   = (phase == bcz_pkg::PHASE_BR);
    beat.zero   = 1'b0;
    beat.weight = wprod[bcz_pkg::WGT_W-1:0];
    beat.col    = c_job.col;
    beat.row    = c_job.row;

    if (c_valid) begin
      if (c_job.cmd == bcz_pkg::CMD_STORE) begin
        ram_en   = store_ok;
        ram_we   = store_ok;
        ram_addr = bcz_pkg::mem_addr(bcz_pkg::ADDR_W'(c_job.col),
                                     bcz_pkg::ADDR_W'(c_job.row));
        c_done   = 1'b1;
      end else if (!c_job.in_bounds) begin
        if (credit) begin
          beat.valid = 1'b1;
          beat.first = 1'b1;
          beat.last  = 1'b1;
          beat.zero  = 1'b1;
          c_done     = 1'b1;
        end
      end else if (phase != bcz_pkg::PHASE_BR || credit) begin
        ram_en     = 1'b1;
        beat.valid = 1'b1;
        if (phase == bcz_pkg::PHASE_BR) begin
          c_done     = 1'b1;
          phase_next = bcz_pkg::PHASE_TL;
        end else begin
          phase_next = phase + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      phase   <= bcz_pkg::PHASE_TL;
      pending <= '0;
    end else begin
      if (job_ready) begin
        c_valid <= job_valid;
      end
      phase   <= phase_next;
      pending <= pending + bcz_pkg::CNT_W'(beat.valid && beat.last)
                         - bcz_pkg::CNT_W'(rsp_valid && rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      c_job <= job;
    end
  end

  bcz_ram #(
    .DATA_W (bcz_pkg::PIX_W),
    .ADDR_W (bcz_pkg::ADDR_W),
    .DEPTH  (bcz_pkg::DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (c_job.pixel_in),
    .rdata (ram_rdata)
  );

  bcz_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .rdata     (ram_rdata),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= bcz_pkg::CNT_W'(bcz_pkg::OUT_DEPTH))
    else $error("pending result count out of range");

  a_rsp_reserved: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != '0))
    else $error("result shown without a reserved slot");

  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    (c_valid && phase != bcz_pkg::PHASE_TL) |->
      $past(c_valid && c_job.cmd == bcz_pkg::CMD_COMPUTE && c_job.in_bounds))
    else $error("neighbor read sequence broken");

endmodule

`default_nettype wire

>>> bench/zoom_checker.sv
// Result checker for bilinear_center_zoom: it follows every accepted pixel, result and register
// transaction, predicts each output pixel from its own frame store and register copy, and
// compares the results field by field. Depends on bcz_pkg for transaction types and sizes.
module zoom_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  bcz_pkg::req_t                   req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  bcz_pkg::rsp_t                   rsp,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bcz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcz_pkg::CFG_W-1:0]       cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import bcz_pkg::*;

  logic [PIX_W-1:0] src_frame [DEPTH];
  cfg_t             regs;
  rsp_t             pending_pixels [$];
  int               errs;
  int               good;

  function automatic longint px_at(input longint x, input longint y);
    return longint'(src_frame[y * MAX_WIDTH + x]);
  endfunction

  function automatic void report_field(input string name, input int want, input int got);
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
    errs++;
  endfunction

  function automatic rsp_t interpolate_pixel(input req_t item);
    rsp_t   res;
    longint one, half_w, half_h, prod_x, prod_y, fl_x, fl_y, fr_x, fr_y;
    longint x0, x1, y0, y1, blend;
    one    = longint'(1) << FRAC_BITS;
    half_w = longint'(regs.image_width);
    if (half_w > MAX_WIDTH) half_w = MAX_WIDTH;
    half_w = half_w >> 1;
    half_h = longint'(regs.image_height);
    if (half_h > MAX_HEIGHT) half_h = MAX_HEIGHT;
    half_h = half_h >> 1;
    prod_x = (longint'(item.col) - half_w) * longint'(regs.inv_zoom_x);
    prod_y = (longint'(item.row) - half_h) * longint'(regs.inv_zoom_y);
    fl_x   = prod_x >>> FRAC_BITS;
    fl_y   = prod_y >>> FRAC_BITS;
    fr_x   = prod_x & (one - 1);
    fr_y   = prod_y & (one - 1);
    res.out_col   = item.col;
    res.out_row   = item.row;
    res.pixel_out = '0;
    if (fl_x >= -half_w && fl_x < half_w && fl_y >= -half_h && fl_y < half_h) begin
      x0 = fl_x + half_w;
      y0 = fl_y + half_h;
      x1 = (x0 + 1 > 2 * half_w - 1) ? 2 * half_w - 1 : x0 + 1;
      y1 = (y0 + 1 > 2 * half_h - 1) ? 2 * half_h - 1 : y0 + 1;
      blend = (one - fr_y) * ((one - fr_x) * px_at(x0, y0) + fr_x * px_at(x1, y0))
            + fr_y * ((one - fr_x) * px_at(x0, y1) + fr_x * px_at(x1, y1));
      blend = blend >>> (2 * FRAC_BITS);
      res.pixel_out = (blend > 255) ? '1 : PIX_W'(blend);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      regs.image_width  = DIM_W'(256);
      regs.image_height = DIM_W'(256);
      regs.inv_zoom_x   = ZOOM_W'(512);
      regs.inv_zoom_y   = ZOOM_W'(512);
      pending_pixels.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("Result with no transaction pending: col %0d row %0d pixel %0d",
                 rsp.out_col, rsp.out_row, rsp.pixel_out);
          errs++;
        end else begin
          want = pending_pixels.pop_front();
          if (rsp.out_col !== want.out_col) report_field("out_col", want.out_col, rsp.out_col);
          if (rsp.out_row !== want.out_row) report_field("out_row", want.out_row, rsp.out_row);
          if (rsp.pixel_out !== want.pixel_out)
            report_field("pixel_out", want.pixel_out, rsp.pixel_out);
          good++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            regs.image_width = DIM_W'(cfg_data);
          end
          REG_IMAGE_HEIGHT: begin
            regs.image_height = DIM_W'(cfg_data);
          end
          REG_INV_ZOOM_X: begin
            regs.inv_zoom_x = ZOOM_W'(cfg_data);
          end
          REG_INV_ZOOM_Y: begin
            regs.inv_zoom_y = ZOOM_W'(cfg_data);
          end
          default: begin
          end
        endcase
      end
      if (req_valid && req_ready) begin
        if (req.cmd == CMD_STORE) begin
          src_frame[req.row * MAX_WIDTH + req.col] = req.pixel_in;
        end else begin
          pending_pixels.push_back(interpolate_pixel(req));
        end
      end
    end
    mismatches  <= errs;
    outstanding <= pending_pixels.size();
    checked     <= good;
  end

endmodule

>>> bench/tb_top.sv
// Top of the bilinear_center_zoom testbench: clock, reset, stimulus, output back-pressure
// and the verdict. Depends on bcz_pkg, the block itself and zoom_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bcz_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(5);

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req_item;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   checked;

  int img_w;
  int img_h;
  int zoom_x;
  int zoom_y;
  int send_idle_pct;
  int recv_idle_pct;
  bit squeeze;
  bit written [DEPTH];
  int n_store;
  int n_compute;
  int n_settings;

  bilinear_center_zoom dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zoom_checker zoom_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The receiver honors one long hold-off on request so the block backs up into its input.
  initial begin
    int hold;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send(input logic cmd, input int col, input int row, input int pix);
    req_t item;
    item.cmd      = cmd;
    item.col      = COORD_W'(col);
    item.row      = COORD_W'(row);
    item.pixel_in = PIX_W'(pix);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic store(input int x, input int y, input int v);
    written[y * MAX_WIDTH + x] = 1'b1;
    n_store++;
    send(CMD_STORE, x, y, v);
  endtask

  task automatic ensure_px(input int x, input int y);
    if (!written[y * MAX_WIDTH + x]) store(x, y, $urandom_range(255));
  endtask

  function automatic bit source_taps(input int col, input int row, output int x0,
                                     output int x1, output int y0, output int y1);
    longint hw, hh, fx, fy;
    hw = ((img_w < MAX_WIDTH) ? img_w : MAX_WIDTH) / 2;
    hh = ((img_h < MAX_HEIGHT) ? img_h : MAX_HEIGHT) / 2;
    fx = ((col - hw) * longint'(zoom_x)) >>> FRAC_BITS;
    fy = ((row - hh) * longint'(zoom_y)) >>> FRAC_BITS;
    x0 = int'(fx + hw);
    y0 = int'(fy + hh);
    x1 = (x0 + 1 > 2 * hw - 1) ? int'(2 * hw - 1) : x0 + 1;
    y1 = (y0 + 1 > 2 * hh - 1) ? int'(2 * hh - 1) : y0 + 1;
    return fx >= -hw && fx < hw && fy >= -hh && fy < hh;
  endfunction

  // Neighbors are written first so that a compute transaction never reads an empty location.
  task automatic compute_at(input int col, input int row);
    int x0, x1, y0, y1;
    if (source_taps(col, row, x0, x1, y0, y1)) begin
      ensure_px(x0, y0);
      ensure_px(x1, y0);
      ensure_px(x0, y1);
      ensure_px(x1, y1);
    end
    n_compute++;
    send(CMD_COMPUTE, col, row, $urandom_range(255));
  endtask

  task automatic random_item();
    int span_x, span_y;
    if ($urandom_range(99) < 35) begin
      span_x = (img_w < 512) ? img_w : 511;
      span_y = (img_h < 512) ? img_h : 511;
      if ($urandom_range(1) == 0) begin
        store($urandom_range(511), $urandom_range(511), $urandom_range(255));
      end else begin
        store($urandom_range(span_x), $urandom_range(span_y), $urandom_range(255));
      end
    end else begin
      span_x = (img_w + 3 < 511) ? img_w + 3 : 511;
      span_y = (img_h + 3 < 511) ? img_h + 3 : 511;
      if ($urandom_range(1) == 0) begin
        compute_at($urandom_range(511), $urandom_range(511));
      end else begin
        compute_at($urandom_range(span_x), $urandom_range(span_y));
      end
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int zx, input int zy,
                           input int count, input bit junk, input int squeeze_at);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_INV_ZOOM_X, zx);
    write_reg(REG_INV_ZOOM_Y, zy);
    if (junk) write_reg(REG_UNUSED, $urandom_range(32767));
    cfg_valid <= 1'b0;
    img_w  = w;
    img_h  = h;
    zoom_x = zx;
    zoom_y = zy;
    n_settings++;
    for (int i = 0; i < count; i++) begin
      if (i == squeeze_at) squeeze = 1'b1;
      random_item();
    end
  endtask

  initial begin
    int drain;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_item  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    img_w  = 256;
    img_h  = 256;
    zoom_x = 512;
    zoom_y = 512;
    n_settings = 1;
    send_idle_pct = 22;
    recv_idle_pct = 76;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    store(511, 511, 255);
    store(0, 0, 0);
    compute_at(128, 128);
    compute_at(0, 0);
    compute_at(511, 511);
    compute_at(511, 0);
    compute_at(0, 511);
    compute_at(129, 131);
    store(128, 128, 255);
    compute_at(128, 128);
    compute_at(300, 77);

    run_phase(8, 8, 1024, 1024, 60, 1'b0, -1);
    run_phase(2, 2, 16384, 16384, 40, 1'b0, -1);
    run_phase(512, 512, 1, 1, 80, 1'b0, -1);
    send_idle_pct = 76;
    recv_idle_pct = 22;
    run_phase(3, 5, 700, 1500, 50, 1'b0, -1);
    run_phase(1, 4, 512, 512, 15, 1'b0, -1);
    run_phase(16, 16, 0, 0, 20, 1'b0, -1);
    run_phase(512, 512, 512, 512, 100, 1'b1, -1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(32, 24, 820, 1300, 120, 1'b0, 30);
    run_phase(64, 512, 2048, 300, 60, 1'b0, -1);

    req_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (outstanding != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    $display("Sent %0d pixel stores and %0d compute requests across %0d register settings.",
             n_store, n_compute, n_settings);
    $display("Ran skewed, reversed and no back-pressure plus one long output stall; %0d checked.",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> bilinear_center_zoom.f
rtl/bcz_pkg.sv
rtl/bcz_ram.sv
rtl/bcz_coord.sv
rtl/bcz_blend.sv
rtl/bilinear_center_zoom.sv
bench/zoom_checker.sv
bench/tb_top.sv
